// ===== src/rtufb_pkg.sv =====
// Package for the RTU request frame builder: queue entry type, status type,
// frame constants and the per-byte CRC-16 update.
// No dependencies.
package rtufb_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  FN_WIDE  = 8'h10;

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [3:0] DATA_BYTES_WIDE  = 4'd8;
   localparam logic [3:0] DATA_BYTES_SHORT = 4'd6;

   typedef struct packed {
      logic [7:0][7:0] data_bytes;
      logic            wide;
   } frame_entry_type;

   typedef struct packed {
      logic [3:0] byte_index;
      logic       pop;
   } back_status_type;

   function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== src/rtufb_if.sv =====
// Request and response channel interfaces of the RTU request frame builder.
// No dependencies.
interface rtufb_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  device_address;
   logic [7:0]  function_code;
   logic [15:0] register_address;
   logic [31:0] length_value;

   modport source (output valid, device_address, function_code, register_address,
                   length_value, input ready);
   modport sink (input valid, device_address, function_code, register_address,
                 length_value, output ready);
endinterface

interface rtufb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== src/rtufb_front.sv =====
// Front end: accepts a request and lays out its data bytes in transmit order.
// Depends on rtufb_pkg and rtufb_req_if.
module rtufb_front (
   rtufb_req_if.sink                 req_bus,
   input  logic                      wr_ready,
   output logic                      wr_valid,
   output rtufb_pkg::frame_entry_type wr_entry
);

   logic wide;

   assign wide            = (req_bus.function_code == rtufb_pkg::FN_WIDE);
   assign wr_valid        = req_bus.valid;
   assign req_bus.ready   = wr_ready;

   always_comb begin
      wr_entry.wide          = wide;
      wr_entry.data_bytes[0] = req_bus.device_address;
      wr_entry.data_bytes[1] = req_bus.function_code;
      wr_entry.data_bytes[2] = req_bus.register_address[15:8];
      wr_entry.data_bytes[3] = req_bus.register_address[7:0];
      if (wide) begin
         wr_entry.data_bytes[4] = req_bus.length_value[31:24];
         wr_entry.data_bytes[5] = req_bus.length_value[23:16];
         wr_entry.data_bytes[6] = req_bus.length_value[15:8];
         wr_entry.data_bytes[7] = req_bus.length_value[7:0];
      end else begin
         wr_entry.data_bytes[4] = req_bus.length_value[15:8];
         wr_entry.data_bytes[5] = req_bus.length_value[7:0];
         wr_entry.data_bytes[6] = 8'h00;
         wr_entry.data_bytes[7] = 8'h00;
      end
   end

endmodule

// ===== src/rtufb_queue.sv =====
// Short request queue between the front end and the serializer.
// Depends on rtufb_pkg.
module rtufb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_valid,
   input  rtufb_pkg::frame_entry_type wr_entry,
   output logic                       wr_ready,
   input  logic                       rd_pop,
   output logic                       rd_valid,
   output rtufb_pkg::frame_entry_type rd_entry,
   output logic [rtufb_pkg::QCNT_W-1:0] count
);

   rtufb_pkg::frame_entry_type       entry_ff [rtufb_pkg::QDEPTH];
   logic [rtufb_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rtufb_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rtufb_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                             push, pop;

   assign wr_ready = (count_ff != rtufb_pkg::QCNT_W'(rtufb_pkg::QDEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = entry_ff[rd_ptr_ff];
   assign count    = count_ff;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== src/rtufb_back.sv =====
// Serializer: sends head entry data bytes one per cycle unless stalled, folds
// each into the CRC, then appends the CRC. Depends on rtufb_pkg, rtufb_rsp_if.
module rtufb_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  rtufb_pkg::frame_entry_type head_entry,
   output rtufb_pkg::back_status_type status,
   rtufb_rsp_if.source                rsp_bus
);

   logic [3:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        load, step, pop;
   logic [3:0]  data_count;
   logic [7:0]  data_byte;

   assign load       = !out_valid_ff || rsp_bus.ready;
   assign step       = head_valid && load;
   assign data_count = head_entry.wide ? rtufb_pkg::DATA_BYTES_WIDE
                                       : rtufb_pkg::DATA_BYTES_SHORT;
   assign data_byte  = head_entry.data_bytes[idx_ff[2:0]];

   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      pop          = 1'b0;
      if (step) begin
         out_valid_in = 1'b1;
         priority if (idx_ff < data_count) begin
            out_byte_in = data_byte;
            out_last_in = 1'b0;
            crc_in      = rtufb_pkg::crc_byte(crc_ff, data_byte);
            idx_in      = idx_ff + 4'd1;
         end else if (idx_ff == data_count) begin
            out_byte_in = crc_ff[7:0];
            out_last_in = 1'b0;
            idx_in      = idx_ff + 4'd1;
         end else begin
            out_byte_in = crc_ff[15:8];
            out_last_in = 1'b1;
            crc_in      = rtufb_pkg::CRC_INIT;
            idx_in      = 4'd0;
            pop         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         crc_ff       <= rtufb_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.frame_byte = out_byte_ff;
   assign rsp_bus.last_byte  = out_last_ff;
   assign status.byte_index  = idx_ff;
   assign status.pop         = pop;

endmodule

// ===== src/rtu_request_frame_builder.sv =====
// Channel   | Dir | Fields
// req_bus   | in  | device_address, function_code, register_address, length_value
// rsp_bus   | out | frame_byte, last_byte
//
// One frame byte per cycle unless stalled: 10 bytes for function 0x10, 8 otherwise.
// The serializer's byte counter sets the frame length; a two-entry queue lets new
// requests enter while a frame is still being sent.
// A held response byte stalls the serializer; the queue absorbs requests meanwhile.
// Reset is synchronous and empties the queue and the output register.
// Top level of the RTU request frame builder. Depends on rtufb_pkg, rtufb_if,
// rtufb_front, rtufb_queue and rtufb_back.
module rtu_request_frame_builder (
   input  logic         clock,
   input  logic         reset,
   rtufb_req_if.sink    req_bus,
   rtufb_rsp_if.source  rsp_bus
);

   logic                                wr_valid, wr_ready;
   rtufb_pkg::frame_entry_type          wr_entry;
   logic                                head_valid;
   rtufb_pkg::frame_entry_type          head_entry;
   rtufb_pkg::back_status_type          back_status;
   logic [rtufb_pkg::QCNT_W-1:0]        q_count;

   rtufb_front u_front (
      .req_bus  (req_bus),
      .wr_ready (wr_ready),
      .wr_valid (wr_valid),
      .wr_entry (wr_entry)
   );

   rtufb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_entry (wr_entry),
      .wr_ready (wr_ready),
      .rd_pop   (back_status.pop),
      .rd_valid (head_valid),
      .rd_entry (head_entry),
      .count    (q_count)
   );

   rtufb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .status     (back_status),
      .rsp_bus    (rsp_bus)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= rtufb_pkg::QCNT_W'(rtufb_pkg::QDEPTH))
      else $error("request queue count out of range");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |-> head_valid)
      else $error("serializer finished a frame with no request queued");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      back_status.pop |=> back_status.byte_index == 4'd0)
      else $error("byte index not cleared after frame end");

   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> q_count != '0)
      else $error("accepted request not held in queue");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      back_status.byte_index <= 4'd9)
      else $error("byte index beyond frame length");

endmodule

// ===== sim/rtu_request_frame_builder_tb.sv =====
// Self-checking testbench for rtu_request_frame_builder: drives requests, predicts every frame
// byte with its own CRC-16 and compares the byte stream under random stalls on both channels.
// Depends on rtufb_pkg, rtufb_if and the RTL of the frame builder.
`timescale 1ns / 100ps

module rtu_request_frame_builder_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 20;

   class frame_checker;
      typedef struct {
         logic [7:0] value;
         logic       last;
      } frame_byte_type;

      frame_byte_type expected_bytes[$];
      int mismatches;
      int bytes_checked;
      int requests;
      int wide_frames;

      function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
         logic fb;
         for (int k = 0; k < 8; k++) begin
            fb = crc[0] ^ data[k];
            crc = crc >> 1;
            if (fb) begin
               crc = crc ^ rtufb_pkg::CRC_POLY;
            end
         end
         return crc;
      endfunction

      function void note_request(logic [7:0] dev, logic [7:0] func, logic [15:0] reg_addr,
                                 logic [31:0] len);
         logic [7:0]     frame [10];
         logic [15:0]    crc;
         int             n;
         frame_byte_type entry;
         crc = rtufb_pkg::CRC_INIT;
         frame[0] = dev;
         frame[1] = func;
         frame[2] = reg_addr[15:8];
         frame[3] = reg_addr[7:0];
         n = 4;
         if (func == rtufb_pkg::FN_WIDE) begin
            frame[4] = len[31:24];
            frame[5] = len[23:16];
            n = 6;
            wide_frames++;
         end
         frame[n] = len[15:8];
         frame[n + 1] = len[7:0];
         n = n + 2;
         for (int i = 0; i < n; i++) begin
            crc = crc_update(crc, frame[i]);
         end
         frame[n] = crc[7:0];
         frame[n + 1] = crc[15:8];
         n = n + 2;
         for (int i = 0; i < n; i++) begin
            entry.value = frame[i];
            entry.last = (i == n - 1);
            expected_bytes.push_back(entry);
         end
         requests++;
      endfunction

      task report_mismatch(string msg);
         if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
         mismatches++;
      endtask

      task check_byte(logic [7:0] value, logic last);
         frame_byte_type exp_byte;
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %b", value, last));
         end else begin
            exp_byte = expected_bytes.pop_front();
            if (value !== exp_byte.value) begin
               report_mismatch($sformatf("frame_byte %02h, expected %02h", value,
                                         exp_byte.value));
            end
            if (last !== exp_byte.last) begin
               report_mismatch($sformatf("last_byte %b, expected %b on byte %02h", last,
                                         exp_byte.last, exp_byte.value));
            end
         end
      endtask

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   rsp_idle_pct;
   logic rsp_hold;
   int   cycle_count = 0;

   frame_checker sb = new();

   rtufb_req_if req_bus();
   rtufb_rsp_if rsp_bus();

   rtu_request_frame_builder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_byte(rsp_bus.frame_byte, rsp_bus.last_byte);
      end
      rsp_bus.ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   task automatic send_request(input logic [7:0] dev, input logic [7:0] func,
                               input logic [15:0] reg_addr, input logic [31:0] len);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.device_address <= dev;
      req_bus.function_code <= func;
      req_bus.register_address <= reg_addr;
      req_bus.length_value <= len;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      sb.note_request(dev, func, reg_addr, len);
   endtask

   task automatic send_random_request();
      int         pick;
      logic [7:0] func;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         func = rtufb_pkg::FN_WIDE;
      end else if (pick < 70) begin
         func = 8'($urandom_range(1, 6));
      end else begin
         func = 8'($urandom);
      end
      send_request(8'($urandom), func, 16'($urandom), 32'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.device_address = '0;
      req_bus.function_code = '0;
      req_bus.register_address = '0;
      req_bus.length_value = '0;
      rsp_bus.ready = 1'b0;
      rsp_hold = 1'b0;
      send_idle_pct = 32;
      rsp_idle_pct = 86;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_request(8'h00, 8'h03, 16'h0000, 32'h0000_0000);
      send_request(8'hFF, 8'h03, 16'hFFFF, 32'h0000_FFFF);
      send_request(8'h01, rtufb_pkg::FN_WIDE, 16'h0000, 32'h0000_0000);
      send_request(8'hFF, rtufb_pkg::FN_WIDE, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(8'h11, rtufb_pkg::FN_WIDE, 16'h8000, 32'h8000_0001);
      send_request(8'h22, 8'h06, 16'h7FFF, 32'hFFFF_0000);
      send_request(8'h33, 8'h04, 16'h1234, 32'hABCD_7FFF);
      send_request(8'h44, 8'h00, 16'h0001, 32'h0000_0001);
      send_request(8'h55, 8'hFF, 16'hFFFE, 32'h1234_5678);
      send_request(8'h66, 8'h0F, 16'h00FF, 32'h0000_7FFF);
      send_request(8'h77, 8'h11, 16'hFF00, 32'h7FFF_FFFF);
      send_request(8'h80, 8'h90, 16'h5555, 32'hAAAA_AAAA);
      send_request(8'hAA, rtufb_pkg::FN_WIDE, 16'hAAAA, 32'h5555_5555);
      send_request(8'h7F, 8'h01, 16'h0010, 32'h0000_0008);
      send_request(8'hFE, 8'h02, 16'h8001, 32'hFFFF_8000);
      send_request(8'h10, 8'h05, 16'hFF00, 32'h0000_FF00);
      send_request(8'h01, rtufb_pkg::FN_WIDE, 16'h0001, 32'h0001_0000);
      send_request(8'hF7, 8'h10, 16'h0000, 32'h7FFF_0000);

      repeat (55) send_random_request();

      send_idle_pct <= 86;
      rsp_idle_pct <= 32;
      repeat (55) send_random_request();

      send_idle_pct <= 0;
      rsp_idle_pct <= 0;
      rsp_hold <= 1'b1;
      fork
         begin
            repeat (150) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (55) send_random_request();
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (30) @(posedge clock);

      $display("Covered %0d requests (%0d long frames), %0d bytes checked under stalls.",
               sb.requests, sb.wide_frames, sb.bytes_checked);
      $display("Mismatches seen: %0d.", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rtufb_pkg.sv
src/rtufb_if.sv
src/rtufb_front.sv
src/rtufb_queue.sv
src/rtufb_back.sv
src/rtu_request_frame_builder.sv
sim/rtu_request_frame_builder_tb.sv
